>>> hdl/dtc_pkg.sv
// Shared types, constants and tables of the differential-drive turn controller.
package dtc_pkg;

  localparam int unsigned AngleW = 15;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned CordicSteps = 14;
  localparam int unsigned RootSteps = 16;
  localparam int unsigned DivSteps = 31;

  localparam logic [15:0] PiQ13 = 16'd25736;
  localparam logic [15:0] HalfPiQ13 = 16'd12868;

  // Configuration register indexes.
  localparam logic [1:0] RegHardTurn = 2'd0;
  localparam logic [1:0] RegSoftTurn = 2'd1;
  localparam logic [1:0] RegNoTurn = 2'd2;
  localparam logic [1:0] RegMaxSpeed = 2'd3;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2
  } turn_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ITER,
    ST_MODE,
    ST_PROD,
    ST_DIVIDE,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [1:0]         turn_mode;
  } out_word_t;

  // Classified heading held in the queue between front and back.
  typedef struct packed {
    logic [15:0] abs_x;
    logic [15:0] abs_y;
    logic        x_neg;
    logic        y_neg;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] hard_turn_angle;
    logic [AngleW-1:0] soft_turn_angle;
    logic [AngleW-1:0] no_turn_angle;
    logic [SpeedW-1:0] speed_limit;
  } cfg_t;

  // Arctangent table, round(atan(2^-i) * 8192).
  function automatic logic [12:0] atan_lut(input logic [3:0] idx);
    logic [12:0] val;
    case (idx)
      4'd0:    val = 13'd6434;
      4'd1:    val = 13'd3798;
      4'd2:    val = 13'd2007;
      4'd3:    val = 13'd1019;
      4'd4:    val = 13'd511;
      4'd5:    val = 13'd256;
      4'd6:    val = 13'd128;
      4'd7:    val = 13'd64;
      4'd8:    val = 13'd32;
      4'd9:    val = 13'd16;
      4'd10:   val = 13'd8;
      4'd11:   val = 13'd4;
      4'd12:   val = 13'd2;
      4'd13:   val = 13'd1;
      default: val = 13'd0;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/dtc_front.sv
// Front end: accepts heading words, splits off signs and magnitudes, and queues them.
module dtc_front import dtc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     pop_i,
  output logic     item_valid_o,
  output item_t    item_o
);

  item_t       entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;
  item_t       item_new;
  logic [16:0] ext_x;
  logic [16:0] ext_y;

  // Classify the incoming word: sign flags and magnitudes.
  always_comb begin
    ext_x = {in_word_i.heading_x[15], in_word_i.heading_x};
    ext_y = {in_word_i.heading_y[15], in_word_i.heading_y};
    item_new.x_neg = in_word_i.heading_x[15];
    item_new.y_neg = in_word_i.heading_y[15];
    item_new.abs_x = in_word_i.heading_x[15] ? 16'(-ext_x) : 16'(ext_x);
    item_new.abs_y = in_word_i.heading_y[15] ? 16'(-ext_y) : 16'(ext_y);
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

>>> hdl/dtc_back.sv
// Back end: CORDIC angle, integer square root, turn-mode update and wheel-speed division.
module dtc_back import dtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  item_t     item_i,
  output logic      pop_o,
  input  cfg_t      cfg_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  back_state_e state_q, state_d;
  turn_mode_e  mode_q, mode_d;
  logic [4:0]  cnt_q;

  logic [15:0]        ax_q, ay_q;
  logic               x_neg_q, y_neg_q;
  logic [31:0]        sqx_q, sqy_q;
  logic signed [26:0] cx_q, cy_q;
  logic signed [15:0] z_q;
  logic [31:0]        rad_q;
  logic [16:0]        rem_q;
  logic [15:0]        root_q;
  logic [15:0]        mag_q;
  logic [SpeedW-1:0]  base_q;
  logic [30:0]        dn1_q, dn2_q;
  logic [14:0]        dr1_q, dr2_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic               out_free;
  logic               last_iter;
  logic               last_div;
  logic               use_div;
  logic signed [26:0] dx, dy;
  logic [12:0]        atan_val;
  logic [18:0]        rem_sh;
  logic [18:0]        trial;
  logic [15:0]        quad;
  logic [15:0]        mag_d;
  logic [SpeedW-1:0]  base_d;
  logic [15:0]        d1;
  logic [15:0]        hsum;
  logic [15:0]        ds1, ds2;
  logic               qb1, qb2;
  logic [14:0]        nr1, nr2;
  logic signed [15:0] s1, s2;
  out_word_t          res;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_iter = (cnt_q == 5'(RootSteps - 1));
  assign last_div  = (cnt_q == 5'(DivSteps - 1));
  assign use_div   = (mode_q == MODE_SOFT) && (cfg_i.hard_turn_angle != '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (item_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_ITER;
      ST_ITER:   if (last_iter) state_d = ST_MODE;
      ST_MODE:   state_d = ST_PROD;
      ST_PROD:   state_d = use_div ? ST_DIVIDE : ST_OUT;
      ST_DIVIDE: if (last_div) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    pop_o = (state_q == ST_IDLE) && item_valid_i;
  end

  // One CORDIC vectoring step and one square-root digit.
  always_comb begin
    dx       = cy_q >>> cnt_q[3:0];
    dy       = cx_q >>> cnt_q[3:0];
    atan_val = atan_lut(cnt_q[3:0]);
    rem_sh   = {rem_q, rad_q[31:30]};
    trial    = {1'b0, root_q, 2'b01};
  end

  // Quadrant angle, turn-mode hysteresis and base speed.
  always_comb begin
    if (ay_q == '0) begin
      quad = '0;
    end else if (ax_q == '0) begin
      quad = HalfPiQ13;
    end else if (z_q < 0) begin
      quad = '0;
    end else if (z_q > $signed(HalfPiQ13)) begin
      quad = HalfPiQ13;
    end else begin
      quad = 16'(z_q);
    end
    mag_d  = x_neg_q ? PiQ13 - quad : quad;
    base_d = (root_q < {1'b0, cfg_i.speed_limit}) ? root_q[SpeedW-1:0] : cfg_i.speed_limit;

    mode_d = mode_q;
    if (mode_d == MODE_HARD && mag_d <= {1'b0, cfg_i.soft_turn_angle}) begin
      mode_d = MODE_SOFT;
    end
    if (mode_d == MODE_SOFT) begin
      if (mag_d > {1'b0, cfg_i.hard_turn_angle}) begin
        mode_d = MODE_HARD;
      end else if (mag_d <= {1'b0, cfg_i.no_turn_angle}) begin
        mode_d = MODE_NONE;
      end
    end
    if (mode_d == MODE_NONE) begin
      if (mag_d > {1'b0, cfg_i.hard_turn_angle}) begin
        mode_d = MODE_HARD;
      end else if (mag_d > {1'b0, cfg_i.no_turn_angle}) begin
        mode_d = MODE_SOFT;
      end
    end
  end

  // Operands of the two divisions and one restoring step of each.
  always_comb begin
    d1   = ({1'b0, cfg_i.hard_turn_angle} > mag_q) ?
           {1'b0, cfg_i.hard_turn_angle} - mag_q : '0;
    hsum = {1'b0, cfg_i.hard_turn_angle} + mag_q;
    ds1  = {dr1_q, dn1_q[30]};
    ds2  = {dr2_q, dn2_q[30]};
    qb1  = ds1 >= {1'b0, cfg_i.hard_turn_angle};
    qb2  = ds2 >= {1'b0, cfg_i.hard_turn_angle};
    nr1  = qb1 ? 15'(ds1 - {1'b0, cfg_i.hard_turn_angle}) : ds1[14:0];
    nr2  = qb2 ? 15'(ds2 - {1'b0, cfg_i.hard_turn_angle}) : ds2[14:0];
  end

  // Wheel speeds from the mode, swapped unless the angle is positive.
  always_comb begin
    if (mode_q == MODE_HARD) begin
      s1 = -$signed({1'b0, cfg_i.speed_limit});
      s2 = $signed({1'b0, cfg_i.speed_limit});
    end else if (use_div) begin
      s1 = $signed(dn1_q[15:0]);
      s2 = (dn2_q > 31'd32767) ? 16'sd32767 : $signed(dn2_q[15:0]);
    end else begin
      s1 = $signed({1'b0, base_q});
      s2 = $signed({1'b0, base_q});
    end
    if (!y_neg_q && mag_q != '0) begin
      res.left_speed  = s1;
      res.right_speed = s2;
    end else begin
      res.left_speed  = s2;
      res.right_speed = s1;
    end
    res.turn_mode = mode_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_NONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MODE) begin
        mode_q <= mode_d;
      end
      if (state_q == ST_ITER || state_q == ST_DIVIDE) begin
        cnt_q <= (last_iter && state_q == ST_ITER) || last_div ? '0 : cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ax_q    <= item_i.abs_x;
        ay_q    <= item_i.abs_y;
        x_neg_q <= item_i.x_neg;
        y_neg_q <= item_i.y_neg;
        cx_q    <= $signed({3'b000, item_i.abs_x, 8'h00});
        cy_q    <= $signed({3'b000, item_i.abs_y, 8'h00});
        z_q     <= '0;
      end
      ST_SQUARE: begin
        sqx_q <= ax_q * ax_q;
        sqy_q <= ay_q * ay_q;
      end
      ST_SUM: begin
        rad_q  <= sqx_q + sqy_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ITER: begin
        if (cnt_q < 5'(CordicSteps)) begin
          if (cy_q >= 0) begin
            cx_q <= cx_q + dx;
            cy_q <= cy_q - dy;
            z_q  <= z_q + $signed({3'b000, atan_val});
          end else begin
            cx_q <= cx_q - dx;
            cy_q <= cy_q + dy;
            z_q  <= z_q - $signed({3'b000, atan_val});
          end
        end
        rad_q <= {rad_q[29:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= 17'(rem_sh - trial);
          root_q <= {root_q[14:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[16:0];
          root_q <= {root_q[14:0], 1'b0};
        end
      end
      ST_MODE: begin
        mag_q  <= mag_d;
        base_q <= base_d;
      end
      ST_PROD: begin
        dn1_q <= {16'd0, base_q} * {15'd0, d1};
        dn2_q <= {16'd0, base_q} * {15'd0, hsum};
        dr1_q <= '0;
        dr2_q <= '0;
      end
      ST_DIVIDE: begin
        dn1_q <= {dn1_q[29:0], qb1};
        dn2_q <= {dn2_q[29:0], qb2};
        dr1_q <= nr1;
        dr2_q <= nr2;
      end
      ST_OUT: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hdl/differential_drive_turn_controller_core.sv
// Top level of the differential-drive turn controller: configuration registers, front and back.
// Each heading word yields one result word with the two wheel speeds and the turn mode.
// The back end handles one word at a time; its time per word is set by the 16-step shared
// CORDIC and square-root loop and, in soft-turn mode, also by the 31-step restoring divider.
// A two-word queue lets the next headings enter while the back end is busy, and the output
// register holds a finished result while the next one is worked out.
module differential_drive_turn_controller_core import dtc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [AngleW-1:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  item_valid;
  logic  pop;
  item_t item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hard_turn_angle <= AngleW'(12868);
      cfg_q.soft_turn_angle <= AngleW'(10008);
      cfg_q.no_turn_angle   <= AngleW'(1430);
      cfg_q.speed_limit     <= SpeedW'(2560);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHardTurn: cfg_q.hard_turn_angle <= cfg_wdata_i;
        RegSoftTurn: cfg_q.soft_turn_angle <= cfg_wdata_i;
        RegNoTurn:   cfg_q.no_turn_angle   <= cfg_wdata_i;
        RegMaxSpeed: cfg_q.speed_limit     <= cfg_wdata_i;
        default:     cfg_q                 <= cfg_q;
      endcase
    end
  end

  dtc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dtc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule
